// ===== hdl/sba_pkg.sv =====
// Shared constants and types for the sector bitmap allocator.
`default_nettype none
package sba_pkg;

    localparam int DEF_MAX_SECTORS = 4096;

    // Bytes held side by side in one bitmap memory row.
    localparam int BYTE_LANES = 4;
    localparam int ROW_W      = BYTE_LANES * 8;

    localparam int ACTION_W = 2;
    localparam int SECTOR_W = 12;
    localparam int COUNT_W  = 13;
    localparam int WHOLE_W  = COUNT_W - 3;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;
    localparam logic [7:0]         FULL_BYTE = 8'hFF;

    // Outcome of searching one bitmap row for a clear bit.
    typedef struct packed {
        logic                hit;
        logic [SECTOR_W-1:0] sector;
    } scan_res_t;

endpackage
`default_nettype wire

// ===== hdl/sba_bitmap_ram.sv =====
// Bitmap row memory: one write port, one registered read port.
`default_nettype none
module sba_bitmap_ram #(
    parameter int ROWS   = 128,
    parameter int ROW_AW = 7
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [ROW_AW-1:0]        waddr,
    input  wire logic [sba_pkg::ROW_W-1:0] wdata,
    input  wire logic [ROW_AW-1:0]        raddr,
    output logic      [sba_pkg::ROW_W-1:0] rdata
);

    logic [sba_pkg::ROW_W-1:0] mem [ROWS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/sba_row_scan.sv =====
// Shared search unit: lowest clear bit among the searchable bytes of one row.
`default_nettype none
module sba_row_scan #(
    parameter int ROW_AW = 7
) (
    input  wire logic [sba_pkg::ROW_W-1:0]   row_data,
    input  wire logic [ROW_AW-1:0]           row_idx,
    input  wire logic [sba_pkg::WHOLE_W-1:0] whole,
    output sba_pkg::scan_res_t               res
);

    logic [sba_pkg::BYTE_LANES-1:0] lane_hit;
    logic [2:0]                     lane_bit [sba_pkg::BYTE_LANES];
    logic [31:0]                    row_base;
    logic [31:0]                    byte_idx;
    logic [31:0]                    sector_w;
    logic [7:0]                     b;

    assign row_base = {{(32-ROW_AW){1'b0}}, row_idx} * 32'(sba_pkg::BYTE_LANES);

    // per lane: eligible, not full, and position of its lowest zero bit
    always_comb begin
        for (int l = 0; l < sba_pkg::BYTE_LANES; l++) begin
            b           = row_data[l*8 +: 8];
            lane_hit[l] = ((row_base + 32'(l)) < {{(32-sba_pkg::WHOLE_W){1'b0}}, whole})
                          && (b != sba_pkg::FULL_BYTE);
            lane_bit[l] = 3'd0;
            for (int j = 7; j >= 0; j--) begin
                if (!b[j]) begin
                    lane_bit[l] = 3'(j);
                end
            end
        end
    end

    always_comb begin
        res.hit  = 1'b0;
        byte_idx = '0;
        sector_w = '0;
        for (int l = sba_pkg::BYTE_LANES - 1; l >= 0; l--) begin
            if (lane_hit[l]) begin
                res.hit  = 1'b1;
                byte_idx = row_base + 32'(l);
                sector_w = {byte_idx[28:0], lane_bit[l]};
            end
        end
        res.sector = sector_w[sba_pkg::SECTOR_W-1:0];
    end

endmodule
`default_nettype wire

// ===== hdl/sector_bitmap_allocator_top.sv =====
// Sector bitmap allocator: sequencer, count register and result register.
//
// Input transfers arrive on s_t*; s_tuser carries the action (load byte,
// set/clear bit, find free sector), s_tdata the sector index, new bit and
// load byte. Each input gives exactly one result transfer on m_t*. The user
// must write sector_count via cfg_we/cfg_wdata only while the block is idle (not enforced).
//
// The bitmap sits in a memory of four-byte rows behind one shared row unit.
// Load and set go from acceptance to result through row read, modify and
// write-back, and result register. Find reads one row per cycle from row 0 and
// stops at the first row holding a clear bit inside the searchable range,
// or with found low after the last searchable row.
// s_tready is low while an item is in progress.
//
// After aresetn the block clears the bitmap one row per cycle with s_tready low;
// the count resets to zero and sector_count to 4096. A stalled m_tready holds
// the result in the output register; the next input may be accepted meanwhile,
// and its result waits until the held one has been taken.
`default_nettype none
module sector_bitmap_allocator_top #(
    parameter int MAX_SECTORS = sba_pkg::DEF_MAX_SECTORS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata,   // sector_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,     // sector_addr[11:0], bit_value[12], load_byte[20:13]
    input  wire logic [1:0]  s_tuser,     // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,     // old_bit[0], bitmap_byte[8:1], used_count[21:9],
                                          // free_sector[33:22]
    output logic      [0:0]  m_tuser      // found[0]
);

    localparam int BYTES  = (MAX_SECTORS + 7) / 8;
    localparam int ROWS   = (BYTES + sba_pkg::BYTE_LANES - 1) / sba_pkg::BYTE_LANES;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW     = sba_pkg::COUNT_W;
    localparam int SW     = sba_pkg::SECTOR_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] cfg_count_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [ROW_AW-1:0] ptr_reg, ptr_next;      // clear pointer, then scan row

    logic [sba_pkg::ACTION_W-1:0] act_reg;
    logic [SW-1:0] sec_reg;
    logic          val_reg;
    logic [7:0]    lbyte_reg;

    logic          old_bit_reg, old_bit_next;
    logic [7:0]    byte_reg, byte_next;
    logic [SW-1:0] free_reg, free_next;
    logic          found_reg, found_next;

    logic          m_valid_reg;
    logic [39:0]   m_data_reg;
    logic          m_found_reg;

    logic                      ram_we;
    logic [ROW_AW-1:0]         ram_waddr, ram_raddr;
    logic [sba_pkg::ROW_W-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0]   eff;
    logic [sba_pkg::WHOLE_W-1:0] whole;
    logic [31:0]     item_idx_w, in_idx_w, next_base;
    logic            in_map;
    logic [1:0]      lane;
    logic [7:0]      prior_byte, after_byte, set_byte, lim_mask;
    logic            old_bit;
    logic            do_write;
    logic [3:0]      pop_new, pop_old;
    logic signed [4:0]  delta;
    logic signed [CW+1:0] sum;
    logic            accept, out_free;
    logic [ROW_AW-1:0] item_row;
    logic [CW+2:0]   sect_j;
    sba_pkg::scan_res_t scan_res;

    sba_bitmap_ram #(.ROWS(ROWS), .ROW_AW(ROW_AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sba_row_scan #(.ROW_AW(ROW_AW)) u_scan (
        .row_data (ram_rdata),
        .row_idx  (ptr_reg),
        .whole    (whole),
        .res      (scan_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

    // effective sector count and whole searchable bytes
    assign eff   = ({{(32-CW){1'b0}}, cfg_count_reg} > 32'(MAX_SECTORS)) ?
                   CW'(MAX_SECTORS) : cfg_count_reg;
    assign whole = eff[CW-1:3];

    assign item_idx_w = {{(32-SW+3){1'b0}}, sec_reg[SW-1:3]};
    assign in_idx_w   = {{(32-SW+3){1'b0}}, s_tdata[SW-1:3]};
    assign item_row   = item_idx_w[2 +: ROW_AW];
    assign in_map     = item_idx_w < 32'(BYTES);
    assign lane       = sec_reg[4:3];
    assign prior_byte = in_map ? ram_rdata[lane*8 +: 8] : 8'h00;
    assign old_bit    = prior_byte[sec_reg[2:0]];
    assign set_byte   = val_reg ? (prior_byte | (8'h01 << sec_reg[2:0]))
                                : (prior_byte & ~(8'h01 << sec_reg[2:0]));
    assign next_base  = ({{(32-ROW_AW){1'b0}}, ptr_reg} + 32'd1) * 32'(sba_pkg::BYTE_LANES);

    // sectors of the addressed byte that lie below the sector count
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            sect_j      = {4'b0, sec_reg[SW-1:3], 3'(j)};
            lim_mask[j] = sect_j < {3'b0, eff};
        end
    end

    always_comb begin
        pop_new = '0;
        pop_old = '0;
        for (int j = 0; j < 8; j++) begin
            pop_new = pop_new + 4'(lbyte_reg[j] & lim_mask[j]);
            pop_old = pop_old + 4'(prior_byte[j] & lim_mask[j]);
        end
    end

    always_comb begin
        delta      = 5'sd0;
        do_write   = 1'b0;
        after_byte = prior_byte;
        case (act_reg)
            sba_pkg::ACT_LOAD: begin
                if (in_map) begin
                    delta      = signed'({1'b0, pop_new}) - signed'({1'b0, pop_old});
                    do_write   = 1'b1;
                    after_byte = lbyte_reg;
                end
            end
            sba_pkg::ACT_SET: begin
                if (in_map && (val_reg != old_bit)) begin
                    delta      = val_reg ? 5'sd1 : -5'sd1;
                    do_write   = 1'b1;
                    after_byte = set_byte;
                end
            end
            default: begin
            end
        endcase
    end

    // saturating count update
    always_comb begin
        sum = signed'({2'b00, count_reg}) + {{(CW-3){delta[4]}}, delta};
        if (sum < 0) begin
            count_next = '0;
        end else if (sum > signed'({2'b00, sba_pkg::COUNT_MAX})) begin
            count_next = sba_pkg::COUNT_MAX;
        end else begin
            count_next = sum[CW-1:0];
        end
    end

    always_comb begin
        ram_wdata = ram_rdata;
        for (int l = 0; l < sba_pkg::BYTE_LANES; l++) begin
            if (2'(l) == lane) begin
                ram_wdata[l*8 +: 8] = after_byte;
            end
        end
        ram_we    = 1'b0;
        ram_waddr = item_row;
        ram_raddr = in_idx_w[2 +: ROW_AW];
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = '0;
            end
            ST_LOOK: begin
                ram_we    = do_write;
                ram_raddr = '0;
            end
            ST_SCAN: begin
                ram_raddr = ptr_reg + ROW_AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        old_bit_next = old_bit_reg;
        byte_next    = byte_reg;
        free_next    = free_reg;
        found_next   = found_reg;
        case (state_reg)
            ST_CLEAR: begin
                ptr_next = ptr_reg + ROW_AW'(1);
                if (ptr_reg == ROW_AW'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                old_bit_next = old_bit;
                byte_next    = in_map ? after_byte : 8'h00;
                free_next    = '0;
                found_next   = 1'b0;
                ptr_next     = '0;
                state_next   = (act_reg == sba_pkg::ACT_FIND) ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                ptr_next = ptr_reg + ROW_AW'(1);
                if (scan_res.hit) begin
                    free_next  = scan_res.sector;
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else if ((ptr_reg == ROW_AW'(ROWS - 1)) ||
                             (next_base >= {{(32-sba_pkg::WHOLE_W){1'b0}}, whole})) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            count_reg     <= '0;
            cfg_count_reg <= CW'(4096);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (cfg_we) begin
                cfg_count_reg <= cfg_wdata;
            end
            if (state_reg == ST_LOOK) begin
                count_reg <= count_next;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg   <= s_tuser;
            sec_reg   <= s_tdata[SW-1:0];
            val_reg   <= s_tdata[12];
            lbyte_reg <= s_tdata[20:13];
        end
        old_bit_reg <= old_bit_next;
        byte_reg    <= byte_next;
        free_reg    <= free_next;
        found_reg   <= found_next;
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg  <= {6'b0, free_reg, count_reg, byte_reg, old_bit_reg};
            m_found_reg <= found_reg;
        end
    end

endmodule
`default_nettype wire
